### hw/rtl/pcrc_pkg.sv
// pcrc_pkg: word types and the byte-wide crc-32 update shared by the
// checksum protect/check block. No dependencies.

package pcrc_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [2:0]  FieldBytes = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } pcrc_in_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        crc_match;
    logic        too_short;
  } pcrc_out_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/pcrc_in_reg.sv
// pcrc_in_reg: input register of the checksum block.
// Uses pcrc_pkg for the input word type.

module pcrc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcrc_pkg::pcrc_in_t in_data_i,
  input  logic              advance_i,
  output logic              valid_o,
  output pcrc_pkg::pcrc_in_t data_o
);
  import pcrc_pkg::*;

  logic     valid_q, valid_d;
  pcrc_in_t data_q;

  // a word may enter when the register is empty or the held one leaves in the same cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_valid_i || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/pcrc_core.sv
// pcrc_core: field capture, running crc and result forming, one byte per cycle
// while no final byte waits for room. Uses pcrc_pkg for word types and crc update.

module pcrc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pcrc_pkg::pcrc_in_t  data_i,
  input  logic               out_free_i,
  output logic               advance_o,
  output logic               result_valid_o,
  output pcrc_pkg::pcrc_out_t result_o
);
  import pcrc_pkg::*;

  logic [31:0] crc_q, crc_d, crc_next;
  logic [31:0] field_q, field_d, field_next;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_next;
  logic        in_header;

  // a non-final byte gives no result, so only the final one waits for room
  assign advance_o      = valid_i && (!data_i.last || out_free_i);
  assign result_valid_o = advance_o && data_i.last;
  assign in_header      = hdr_cnt_q < FieldBytes;

  always_comb begin
    crc_next     = crc_q;
    field_next   = field_q;
    hdr_cnt_next = hdr_cnt_q;
    if (in_header) begin
      field_next[{hdr_cnt_q[1:0], 3'b000} +: 8] =
        field_q[{hdr_cnt_q[1:0], 3'b000} +: 8] | data_i.data_byte;
      hdr_cnt_next = hdr_cnt_q + 3'd1;
    end else begin
      crc_next = crc_byte(crc_q, data_i.data_byte);
    end
  end

  always_comb begin
    result_o = '0;
    if (hdr_cnt_next < FieldBytes) begin
      result_o.too_short = 1'b1;
    end else begin
      result_o.crc_value = crc_next;
      result_o.crc_match = (crc_next == field_next);
    end
  end

  always_comb begin
    crc_d     = crc_q;
    field_d   = field_q;
    hdr_cnt_d = hdr_cnt_q;
    if (advance_o) begin
      if (data_i.last) begin
        crc_d     = '0;
        field_d   = '0;
        hdr_cnt_d = '0;
      end else begin
        crc_d     = crc_next;
        field_d   = field_next;
        hdr_cnt_d = hdr_cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= '0;
      field_q   <= '0;
      hdr_cnt_q <= '0;
    end else begin
      crc_q     <= crc_d;
      field_q   <= field_d;
      hdr_cnt_q <= hdr_cnt_d;
    end
  end

  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= FieldBytes)
    else $error("header count past field length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (hdr_cnt_q == '0) && (crc_q == '0) && (field_q == '0))
    else $error("state not cleared after final byte");

  a_short_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.too_short |-> (result_o.crc_value == '0) && !result_o.crc_match)
    else $error("short unit with nonzero crc fields");

  a_crc_idle_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && !data_i.last && in_header |=> crc_q == '0)
    else $error("crc moved while capturing the field");

endmodule

### hw/rtl/pcrc_out_reg.sv
// pcrc_out_reg: result register of the checksum block.
// Uses pcrc_pkg for the result word type.

module pcrc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pcrc_pkg::pcrc_out_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcrc_pkg::pcrc_out_t out_data_o
);
  import pcrc_pkg::*;

  logic      valid_q, valid_d;
  pcrc_out_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hw/rtl/pdu_crc32_protect_check_unit.sv
// pdu_crc32_protect_check_unit: top level of the checksum protect/check block.
// Depends on pcrc_pkg, pcrc_in_reg, pcrc_core and pcrc_out_reg.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) takes one byte of a
//   serialised data unit per word, with last set on the final byte. The first
//   four bytes are the little-endian checksum field; every later byte runs
//   through a reflected crc-32 (poly 0xEDB88320, seed 0, no final xor).
//   The output channel (out_valid_o/out_ready_i/out_data_o) carries one word
//   per unit: the computed crc, a match flag against the captured field, and
//   too_short for units under four bytes (crc and match then read 0).
//   Throughput is one byte per cycle when no final byte waits for room,
//   bounded by the byte-wide crc update between the input register and the
//   result register, which holds each unit's result and drives out_valid_o.
//   Reset clears both valid flags, the running crc, the captured field and
//   the header count; the block then takes a byte on the next edge.
//   A stalled receiver holds the result; non-final bytes keep flowing, and a
//   final byte waits in the input register until the result register frees.

module pdu_crc32_protect_check_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pcrc_pkg::pcrc_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcrc_pkg::pcrc_out_t out_data_o
);
  import pcrc_pkg::*;

  logic      stage_valid;
  pcrc_in_t  stage_data;
  logic      advance;
  logic      out_free;
  logic      result_valid;
  pcrc_out_t result;

  pcrc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .data_o     (stage_data)
  );

  pcrc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (stage_valid),
    .data_i         (stage_data),
    .out_free_i     (out_free),
    .advance_o      (advance),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  pcrc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (result_valid),
    .data_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/sv/pdu_crc32_checker.sv
`timescale 1ns / 100ps
// crc32_tb_pkg holds the byte-wise reflected crc-32 used by the testbench, and
// pdu_crc32_checker predicts and checks result words of the protect/check unit.
// Depends on pcrc_pkg for the channel word types.

package crc32_tb_pkg;

  localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB88320;

  // one data byte into the running crc, bit by bit, lsb first
  function automatic logic [31:0] crc32_refl_step(input logic [31:0] crc,
                                                  input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[31:1]};
      if (fb) begin
        c = c ^ CRC32_POLY_REFL;
      end
    end
    return c;
  endfunction

endpackage

module pdu_crc32_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pcrc_pkg::pcrc_in_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pcrc_pkg::pcrc_out_t out_word_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int HDR_BYTES  = 4;
  localparam int MAX_PRINTS = 40;

  logic [31:0]         crc_acc;
  logic [31:0]         field_word;
  logic [2:0]          field_cnt;
  pcrc_pkg::pcrc_out_t crc_results_q[$];
  pcrc_pkg::pcrc_out_t got;
  pcrc_pkg::pcrc_out_t want;
  pcrc_pkg::pcrc_out_t predicted;
  int                  mismatches = 0;
  int                  pending_cnt = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_cnt;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] crc check: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc     = '0;
      field_word  = '0;
      field_cnt   = '0;
      crc_results_q.delete();
      pending_cnt = 0;
    end else begin
      // results leave before the byte of this edge is predicted
      if (out_valid_i && out_ready_i) begin
        got = out_word_i;
        if (crc_results_q.size() == 0) begin
          report_mismatch($sformatf("result word with none expected, crc %08h", got.crc_value));
        end else begin
          want = crc_results_q.pop_front();
          if (got.crc_value !== want.crc_value) begin
            report_mismatch($sformatf("crc_value %08h, expected %08h",
                                      got.crc_value, want.crc_value));
          end
          if (got.crc_match !== want.crc_match) begin
            report_mismatch($sformatf("crc_match %b, expected %b",
                                      got.crc_match, want.crc_match));
          end
          if (got.too_short !== want.too_short) begin
            report_mismatch($sformatf("too_short %b, expected %b",
                                      got.too_short, want.too_short));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (int'(field_cnt) < HDR_BYTES) begin
          // checksum field arrives little-endian
          field_word[8*field_cnt +: 8] = in_word_i.data_byte;
          field_cnt = field_cnt + 3'd1;
        end else begin
          crc_acc = crc32_tb_pkg::crc32_refl_step(crc_acc, in_word_i.data_byte);
        end
        if (in_word_i.last) begin
          if (int'(field_cnt) < HDR_BYTES) begin
            predicted.crc_value = '0;
            predicted.crc_match = 1'b0;
            predicted.too_short = 1'b1;
          end else begin
            predicted.crc_value = crc_acc;
            predicted.crc_match = (crc_acc == field_word);
            predicted.too_short = 1'b0;
          end
          crc_results_q.push_back(predicted);
          crc_acc    = '0;
          field_word = '0;
          field_cnt  = '0;
        end
      end
      pending_cnt = crc_results_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for pdu_crc32_protect_check_unit, checksum units
// sent byte by byte with random sender gaps and receiver stalls.
// Depends on pcrc_pkg, crc32_tb_pkg and pdu_crc32_checker.

module tb_top;

  import pcrc_pkg::*;

  localparam int ITEM_TARGET    = 1150;
  localparam int LONG_HOLD      = 500;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {FIELD_RANDOM, FIELD_GOOD, FIELD_CORRUPT} unit_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  pcrc_in_t  in_word;
  logic      out_valid;
  logic      out_ready;
  pcrc_out_t out_word;
  int        fail_count;
  int        pending;
  int        burst_left;
  int        bytes_sent = 0;
  int        hold_reqs = 0;
  int        idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pdu_crc32_protect_check_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  pdu_crc32_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int next_burst();
    if ($urandom_range(0, 9) == 0) begin
      return 300;
    end
    return $urandom_range(1, 24);
  endfunction

  // offer one byte, hold it until taken, then maybe open a gap
  task automatic put_byte(input logic [7:0] data, input logic last);
    int gap;
    in_valid          = 1'b1;
    in_word.data_byte = data;
    in_word.last      = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      in_word  = pcrc_in_t'($urandom_range(0, 511));
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
      burst_left = next_burst();
    end
  endtask

  task automatic send_unit(input int len, input unit_kind_e kind);
    logic [7:0]  pay [0:63];
    logic [31:0] fld;
    logic [31:0] crc;
    int          idx;
    crc = '0;
    for (int i = 0; i < len - 4; i++) begin
      pay[i] = 8'($urandom_range(0, 255));
      crc    = crc32_tb_pkg::crc32_refl_step(crc, pay[i]);
    end
    fld = (kind == FIELD_RANDOM) ? $urandom : crc;
    if (kind == FIELD_CORRUPT) begin
      if (len > 4 && $urandom_range(0, 1) == 1) begin
        idx      = $urandom_range(0, len - 5);
        pay[idx] = pay[idx] ^ (8'd1 << $urandom_range(0, 7));
      end else begin
        fld = fld ^ (32'd1 << $urandom_range(0, 31));
      end
    end
    for (int i = 0; i < len; i++) begin
      if (i < 4) begin
        put_byte(fld[8*i +: 8], i == len - 1);
      end else begin
        put_byte(pay[i-4], i == len - 1);
      end
    end
  endtask

  task automatic send_random_unit();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      send_unit($urandom_range(1, 3), FIELD_RANDOM);
    end else if (pick == 2) begin
      send_unit($urandom_range(16, 64), unit_kind_e'($urandom_range(0, 2)));
    end else begin
      send_unit($urandom_range(4, 16), unit_kind_e'($urandom_range(0, 2)));
    end
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    int       hold_left;
    int       hold_taken;
    out_ready  = 1'b0;
    mode       = RX_OPEN;
    mode_left  = 0;
    tick       = 0;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(negedge clk);
      if (hold_taken != hold_reqs) begin
        hold_taken = hold_reqs;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 4));
          mode_left = $urandom_range(50, 250);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:   out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready = ($urandom_range(0, 9) != 0);
          RX_SPARSE: out_ready = ($urandom_range(0, 4) == 0);
          default:   out_ready = ((tick % 7) > 2);
        endcase
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    bit mid_hold_done;
    mid_hold_done = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    burst_left = next_burst();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // units too short to hold the field
    put_byte(8'hFF, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b1);
    put_byte(8'hAA, 1'b0);
    put_byte(8'h55, 1'b0);
    put_byte(8'h80, 1'b1);
    // field only: zero field matches the empty crc, all ones does not
    repeat (3) put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    repeat (3) put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);
    // zero field over a zero byte still gives crc 0
    repeat (4) put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    send_unit(8, FIELD_GOOD);

    // receiver held off while short units keep coming
    hold_reqs++;
    repeat (25) send_unit($urandom_range(4, 6), unit_kind_e'($urandom_range(0, 2)));
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    while (bytes_sent < ITEM_TARGET) begin
      if (!mid_hold_done && bytes_sent > ITEM_TARGET / 2) begin
        mid_hold_done = 1'b1;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        hold_reqs++;
      end
      send_random_unit();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### pdu_crc32_protect_check_unit.f
hw/rtl/pcrc_pkg.sv
hw/rtl/pcrc_in_reg.sv
hw/rtl/pcrc_core.sv
hw/rtl/pcrc_out_reg.sv
hw/rtl/pdu_crc32_protect_check_unit.sv
tb/sv/pdu_crc32_checker.sv
tb/sv/tb_top.sv
